### rtl/beam_free_space_sampler_core_assert.svh
// Assertion helpers used by the checker file of this block.
`ifndef BEAM_FREE_SPACE_SAMPLER_CORE_ASSERT_SVH
`define BEAM_FREE_SPACE_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfs same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfs next-cycle check failed");

`endif

### rtl/bfs_pkg.sv
package bfs_pkg;

  localparam int COORD_W       = 32;
  localparam int DELTA_W       = 33;
  localparam int SQ_W          = 66;
  localparam int LEN_W         = 33;
  localparam int DIST_W        = 31;
  localparam int DIR_FRAC_BITS = 30;
  localparam int DIR_W         = 31;
  localparam int SQ_REM_W      = 36;
  localparam int ITER_W        = 6;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [ITER_W-1:0] SQRT_ITERS  = 6'd33;
  localparam logic [ITER_W-1:0] DIV_K_ITERS = 6'd33;
  localparam logic [ITER_W-1:0] DIV_N_ITERS = 6'd31;

  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_STEP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LIMIT = 3'd4;

  // Axis selector; AX_K also selects the sample count divide and the
  // final add of a free point.
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] AX_K = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_RL,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_HIT_OUT,
    OP_PT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic len_zero;
    logic iter_last;
    logic out_busy;
    logic all_done;
  } dp_status_t;

endpackage

### rtl/bfs_ctrl.sv
module bfs_ctrl import bfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQZ  = 4'd3;
  localparam logic [3:0] S_SQR  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DSEL = 4'd7;
  localparam logic [3:0] S_DRUN = 4'd8;
  localparam logic [3:0] S_DSTO = 4'd9;
  localparam logic [3:0] S_HOUT = 4'd10;
  localparam logic [3:0] S_WAIT = 4'd11;
  localparam logic [3:0] S_PX   = 4'd12;
  localparam logic [3:0] S_PY   = 4'd13;
  localparam logic [3:0] S_PZ   = 4'd14;
  localparam logic [3:0] S_PW   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] div_ax_q, div_ax_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      div_ax_q <= AX_K;
    end else begin
      state_q  <= state_d;
      div_ax_q <= div_ax_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    div_ax_d    = div_ax_q;
    cmd_o.op    = OP_NONE;
    cmd_o.axis  = AX_X;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_SQX;
        end
      end
      S_SQX: begin
        cmd_o.op   = OP_SQ;
        cmd_o.axis = AX_X;
        state_d    = S_SQY;
      end
      S_SQY: begin
        cmd_o.op   = OP_SQ;
        cmd_o.axis = AX_Y;
        state_d    = S_SQZ;
      end
      S_SQZ: begin
        cmd_o.op   = OP_SQ;
        cmd_o.axis = AX_Z;
        state_d    = S_SQR;
      end
      S_SQR: begin
        cmd_o.op = OP_RL;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (status_i.drop) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_SQRT_INIT;
          state_d  = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (status_i.iter_last) begin
          div_ax_d = AX_K;
          state_d  = S_DSEL;
        end
      end
      S_DSEL: begin
        // A zero-length beam needs neither the count nor the direction.
        if (div_ax_q == AX_K && status_i.len_zero) begin
          state_d = S_HOUT;
        end else begin
          cmd_o.op   = OP_DIV_INIT;
          cmd_o.axis = div_ax_q;
          state_d    = S_DRUN;
        end
      end
      S_DRUN: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.iter_last) begin
          state_d = S_DSTO;
        end
      end
      S_DSTO: begin
        cmd_o.op   = OP_DIV_STORE;
        cmd_o.axis = div_ax_q;
        if (div_ax_q == AX_Z) begin
          state_d = S_HOUT;
        end else begin
          div_ax_d = (div_ax_q == AX_K) ? AX_X : div_ax_q + 2'd1;
          state_d  = S_DSEL;
        end
      end
      S_HOUT: begin
        cmd_o.op = OP_HIT_OUT;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (!status_i.out_busy) begin
          state_d = status_i.all_done ? S_IDLE : S_PX;
        end
      end
      S_PX: begin
        cmd_o.op   = OP_PT;
        cmd_o.axis = AX_X;
        state_d    = S_PY;
      end
      S_PY: begin
        cmd_o.op   = OP_PT;
        cmd_o.axis = AX_Y;
        state_d    = S_PZ;
      end
      S_PZ: begin
        cmd_o.op   = OP_PT;
        cmd_o.axis = AX_Z;
        state_d    = S_PW;
      end
      S_PW: begin
        cmd_o.op   = OP_PT;
        cmd_o.axis = AX_K;
        state_d    = S_WAIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/bfs_datapath.sv
module bfs_datapath import bfs_pkg::*; #(
  parameter int MaxFree   = 62,
  parameter int StepReset = 6554
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [3*COORD_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [3*COORD_W-1:0]  m_axis_tdata_o,
  output logic [1:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o
);

  localparam int CntW = $clog2(MaxFree + 1);
  localparam logic [CntW-1:0] MaxFreeC = CntW'(MaxFree);

  // Configuration registers.
  logic signed [COORD_W-1:0] org_q [3];
  logic [DIST_W-1:0]         step_q, rl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      step_q   <= DIST_W'(StepReset);
      rl_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_ORIGIN_X:    org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:    org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:    org_q[2] <= cfg_data_i;
        REG_SAMPLE_STEP: step_q   <= cfg_data_i[DIST_W-1:0];
        REG_RANGE_LIMIT: rl_q     <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [DIST_W-1:0] step_eff;
  logic [LEN_W-1:0]  step_ext;
  assign step_eff = (step_q == '0) ? DIST_W'(1) : step_q;
  assign step_ext = {2'b00, step_eff};

  // Beam state.
  logic [COORD_W-1:0]  p_q [3];
  logic [DELTA_W-1:0]  u_q [3];
  logic [2:0]          neg_q;
  logic [DIR_W-1:0]    n_q [3];
  logic [SQ_W-1:0]     acc_q, prod_q, sq_src_q;
  logic [SQ_REM_W-1:0] sq_rem_q;
  logic [LEN_W-1:0]    len_q, k_q, t_q;
  logic [LEN_W-1:0]    dv_rem_q, dv_dvd_q, dv_div_q, dv_quo_q;
  logic [ITER_W-1:0]   iter_q;
  logic [CntW-1:0]     i_q, emit_q;
  logic                cut_q, is_hit_q, trunc_q, last_q, out_valid_q;

  logic [1:0] ax_lo, ax_m1;
  assign ax_lo = (cmd_i.axis == AX_K) ? AX_X : cmd_i.axis;
  assign ax_m1 = cmd_i.axis - 2'd1;

  // Free-point distance: loop samples first, then the closing one.
  logic [LEN_W-1:0] t_cur;
  assign t_cur = ({{(LEN_W-CntW){1'b0}}, i_q} < k_q) ? t_q : len_q - step_ext;

  logic [LEN_W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQ: begin
        mul_a = u_q[ax_lo];
        mul_b = u_q[ax_lo];
      end
      OP_RL: begin
        mul_a = {2'b00, rl_q};
        mul_b = {2'b00, rl_q};
      end
      OP_PT: begin
        mul_a = {2'b00, n_q[ax_lo]};
        mul_b = t_cur;
      end
      default: ;
    endcase
  end

  // Square root: two radicand bits per step.
  logic [SQ_REM_W-1:0] sq_sh, sq_trial;
  logic                sq_ge;
  assign sq_sh    = {sq_rem_q[SQ_REM_W-3:0], sq_src_q[SQ_W-1:SQ_W-2]};
  assign sq_trial = {1'b0, len_q, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // Restoring divider: one quotient bit per step.
  logic [LEN_W:0]   dv_sh, dv_diff;
  logic             dv_ge;
  assign dv_sh   = {dv_rem_q, dv_dvd_q[LEN_W-1]};
  assign dv_diff = dv_sh - {1'b0, dv_div_q};
  assign dv_ge   = (dv_sh >= {1'b0, dv_div_q});

  // Rounded offset of the axis whose product is waiting.
  logic [SQ_W-1:0]    rnd;
  logic [DELTA_W-1:0] off;
  logic [COORD_W+1:0] org_ext, pnt;
  assign rnd     = prod_q + (SQ_W'(1) << (DIR_FRAC_BITS - 1));
  assign off     = rnd[DIR_FRAC_BITS+DELTA_W-1:DIR_FRAC_BITS];
  assign org_ext = {{2{org_q[ax_m1][COORD_W-1]}}, org_q[ax_m1]};
  assign pnt     = neg_q[ax_m1] ? org_ext - {1'b0, off} : org_ext + {1'b0, off};

  logic [LEN_W:0]  total;
  logic            closing, cut;
  logic [CntW-1:0] emit, i_next;
  assign closing = (len_q > step_ext);
  assign total   = {1'b0, k_q} + {{LEN_W{1'b0}}, closing};
  assign cut     = (total > (LEN_W+1)'(MaxFree));
  assign emit    = cut ? MaxFreeC : total[CntW-1:0];
  assign i_next  = i_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_HIT_OUT || (cmd_i.op == OP_PT && cmd_i.axis == AX_K)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          logic [DELTA_W-1:0] d;
          d = {s_axis_tdata_i[COORD_W*a+COORD_W-1], s_axis_tdata_i[COORD_W*a +: COORD_W]}
            - {org_q[a][COORD_W-1], org_q[a]};
          neg_q[a] <= d[DELTA_W-1];
          u_q[a]   <= d[DELTA_W-1] ? (~d + 1'b1) : d;
          p_q[a]   <= s_axis_tdata_i[COORD_W*a +: COORD_W];
        end
      end
      OP_SQ: begin
        prod_q <= mul_a * mul_b;
        acc_q  <= (cmd_i.axis == AX_X) ? '0 : acc_q + prod_q;
      end
      OP_RL: begin
        prod_q <= mul_a * mul_b;
        acc_q  <= acc_q + prod_q;
      end
      OP_SQRT_INIT: begin
        sq_src_q <= acc_q;
        sq_rem_q <= '0;
        len_q    <= '0;
        k_q      <= '0;
        iter_q   <= SQRT_ITERS;
      end
      OP_SQRT_STEP: begin
        sq_rem_q <= sq_ge ? sq_sh - sq_trial : sq_sh;
        len_q    <= {len_q[LEN_W-2:0], sq_ge};
        sq_src_q <= sq_src_q << 2;
        iter_q   <= iter_q - 1'b1;
      end
      OP_DIV_INIT: begin
        dv_quo_q <= '0;
        if (cmd_i.axis == AX_K) begin
          dv_rem_q <= '0;
          dv_dvd_q <= len_q - 1'b1;
          dv_div_q <= step_ext;
          iter_q   <= DIV_K_ITERS;
        end else begin
          // The upper quotient bits are zero since |d| never exceeds L.
          dv_rem_q <= {1'b0, u_q[cmd_i.axis][DELTA_W-1:1]};
          dv_dvd_q <= {u_q[cmd_i.axis][0], {(LEN_W-1){1'b0}}};
          dv_div_q <= len_q;
          iter_q   <= DIV_N_ITERS;
        end
      end
      OP_DIV_STEP: begin
        dv_rem_q <= dv_ge ? dv_diff[LEN_W-1:0] : dv_sh[LEN_W-1:0];
        dv_dvd_q <= dv_dvd_q << 1;
        dv_quo_q <= {dv_quo_q[LEN_W-2:0], dv_ge};
        iter_q   <= iter_q - 1'b1;
      end
      OP_DIV_STORE: begin
        if (cmd_i.axis == AX_K) begin
          k_q <= dv_quo_q;
        end else begin
          n_q[cmd_i.axis] <= dv_quo_q[DIR_W-1:0];
        end
      end
      OP_HIT_OUT: begin
        emit_q   <= emit;
        cut_q    <= cut;
        is_hit_q <= 1'b1;
        trunc_q  <= 1'b0;
        last_q   <= (emit == '0);
        i_q      <= '0;
        t_q      <= step_ext;
      end
      OP_PT: begin
        if (cmd_i.axis != AX_K) begin
          prod_q <= mul_a * mul_b;
        end
        if (cmd_i.axis != AX_X) begin
          p_q[ax_m1] <= pnt[COORD_W-1:0];
        end
        if (cmd_i.axis == AX_K) begin
          is_hit_q <= 1'b0;
          last_q   <= (i_next == emit_q);
          trunc_q  <= (i_next == emit_q) && cut_q;
          i_q      <= i_next;
          t_q      <= t_q + step_ext;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {p_q[2], p_q[1], p_q[0]};
  assign m_axis_tuser_o  = {trunc_q, is_hit_q};
  assign m_axis_tlast_o  = last_q;

  assign status_o.drop      = (rl_q != '0) && (acc_q > prod_q);
  assign status_o.len_zero  = (len_q == '0);
  assign status_o.iter_last = (iter_q == ITER_W'(1));
  assign status_o.out_busy  = out_valid_q;
  assign status_o.all_done  = (i_q == emit_q);

endmodule

### rtl/beam_free_space_sampler_core.sv
// Free-space sampler for range beams. Each accepted hit point (signed
// fixed point, in the same raw scale as the origin and step registers)
// yields the hit itself, flagged occupied, followed by free points along
// the beam from the sensor origin, one per sample step, with a closing
// point one step short of the hit; a hit past a nonzero range limit
// yields nothing. One hit is processed at a time. A dropped hit frees
// the block for the next one after the range check. A kept hit is
// offered as its hit point once the squares and the range check, the
// bit-serial square root, the sample-count divide and the three
// direction divides in one shared restoring divider (all divides are
// skipped for a zero-length beam) are done and the output register is
// loaded; each free point is then computed after the previous result is
// taken, passing three times through the shared multiplier on the way,
// so output back-pressure delays it.
module beam_free_space_sampler_core import bfs_pkg::*; #(
  parameter int MAX_FREE_SAMPLES = 62,
  parameter int COORD_FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // hit_x [31:0], hit_y [63:32], hit_z [95:64]
  input  logic [3*COORD_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  output logic [3*COORD_W-1:0]  m_axis_tdata_o,
  // is_hit [0], truncated [1]
  output logic [1:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  // Reset step is one tenth of a unit, rounded.
  localparam int STEP_RESET = ((1 << COORD_FRAC_BITS) + 5) / 10;

  dp_cmd_t    cmd;
  dp_status_t status;

  bfs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  bfs_datapath #(
    .MaxFree   (MAX_FREE_SAMPLES),
    .StepReset (STEP_RESET)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

### rtl/bfs_checker.sv
`include "beam_free_space_sampler_core_assert.svh"

module bfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // A stalled result stays offered.
  `BFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // A new hit is taken only once every result of the previous one is gone.
  `BFS_ASSERT_IMPL(a_one_beam, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)

  // After a hit is taken the block is busy with it.
  `BFS_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // Truncation is only flagged on the last free point of a beam.
  `BFS_ASSERT_IMPL(a_trunc, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[1],
                   m_axis_tlast_o && !m_axis_tuser_o[0])

endmodule

bind beam_free_space_sampler_core bfs_checker u_bfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### sim/beam_free_space_sampler_core_tb.sv
`timescale 1ns / 1ps

module beam_free_space_sampler_core_tb;
  import bfs_pkg::*;

  localparam int MaxFree  = 62;
  localparam int FracBits = 16;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        is_hit;
    logic        truncated;
    logic        last;
  } beam_point_t;

  typedef logic [3*COORD_W-1:0] hit_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  hit_word_t s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  hit_word_t m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  beam_free_space_sampler_core #(
    .MAX_FREE_SAMPLES(MaxFree),
    .COORD_FRAC_BITS (FracBits)
  ) i_dut (.*);

  // Shadow copy of the configuration registers.
  logic signed [31:0] origin_q[3];
  logic [30:0] step_q;
  logic [30:0] range_q;

  hit_word_t   pending_hits[$];
  beam_point_t expected_points[$];
  int errors = 0;
  int hits_sent = 0;
  int hits_dropped = 0;
  int points_seen = 0;
  int truncated_beams = 0;
  longint cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Expand one hit into its occupied point and the free points along the beam.
  function automatic void sample_beam(hit_word_t hw);
    logic signed [31:0] h[3];
    longint d[3];
    logic [63:0] u[3], n[3];
    logic [127:0] s, r2, c2;
    logic [63:0] len, c, stp, k, total, emit, t, off;
    logic closing, cut;
    beam_point_t bp;
    longint p;
    logic [31:0] pa[3];
    h[0] = hw[31:0];
    h[1] = hw[63:32];
    h[2] = hw[95:64];
    for (int a = 0; a < 3; a++) begin
      d[a] = longint'(h[a]) - longint'(origin_q[a]);
      u[a] = d[a] < 0 ? 64'(-d[a]) : 64'(d[a]);
    end
    s = {64'b0, u[0]} * {64'b0, u[0]} + {64'b0, u[1]} * {64'b0, u[1]}
        + {64'b0, u[2]} * {64'b0, u[2]};
    if (range_q != 0) begin
      r2 = {97'b0, range_q} * {97'b0, range_q};
      if (s > r2) begin
        hits_dropped++;
        return;
      end
    end
    len = 0;
    for (int b = 33; b >= 0; b--) begin
      c = len | (64'd1 << b);
      c2 = {64'b0, c} * {64'b0, c};
      if (c2 <= s) len = c;
    end
    stp = (step_q == 0) ? 64'd1 : {33'b0, step_q};
    k = 0;
    n = '{default: 64'd0};
    if (len > 0) begin
      k = (len - 1) / stp;
      for (int a = 0; a < 3; a++) n[a] = (u[a] << DIR_FRAC_BITS) / len;
    end
    closing = len > stp;
    total = k + (closing ? 64'd1 : 64'd0);
    cut = total > MaxFree;
    emit = cut ? 64'(MaxFree) : total;
    if (cut) truncated_beams++;
    bp.x = h[0];
    bp.y = h[1];
    bp.z = h[2];
    bp.is_hit = 1'b1;
    bp.truncated = 1'b0;
    bp.last = (emit == 0);
    expected_points = {expected_points, bp};
    for (longint i = 0; i < emit; i++) begin
      t = (i < k) ? 64'(i + 1) * stp : len - stp;
      for (int a = 0; a < 3; a++) begin
        off = (n[a] * t + (64'd1 << (DIR_FRAC_BITS - 1))) >> DIR_FRAC_BITS;
        p = d[a] < 0 ? longint'(origin_q[a]) - longint'(off)
                     : longint'(origin_q[a]) + longint'(off);
        pa[a] = p[31:0];
      end
      bp.x = pa[0];
      bp.y = pa[1];
      bp.z = pa[2];
      bp.is_hit = 1'b0;
      bp.last = (i + 1 == emit);
      bp.truncated = bp.last && cut;
      expected_points = {expected_points, bp};
    end
  endfunction

  // Hit driver.
  int hit_gap = 0;
  always @(posedge clk_i) begin
    logic next_valid;
    hit_word_t next_data;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d points still expected", $realtime, expected_points.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    next_valid = s_axis_tvalid_i;
    next_data = s_axis_tdata_i;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sample_beam(s_axis_tdata_i);
      hits_sent++;
      next_valid = 1'b0;
      hit_gap = rand_gap();
    end
    if (!next_valid && rst_ni) begin
      if (hit_gap > 0) begin
        hit_gap--;
      end else if (pending_hits.size() > 0) begin
        next_valid = 1'b1;
        next_data = pending_hits.pop_front();
      end
    end
    s_axis_tvalid_i <= next_valid;
    s_axis_tdata_i <= next_data;
  end

  // Point monitor with random back-pressure.
  always @(posedge clk_i) begin
    beam_point_t exp_pt;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point, actual data %h user %b last %b", $realtime,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (m_axis_tdata_o !== {exp_pt.z, exp_pt.y, exp_pt.x}) begin
          $display("%0t: point mismatch, expected %h actual %h", $realtime,
                   {exp_pt.z, exp_pt.y, exp_pt.x}, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o !== {exp_pt.truncated, exp_pt.is_hit}) begin
          $display("%0t: truncated/is_hit mismatch, expected %b actual %b", $realtime,
                   {exp_pt.truncated, exp_pt.is_hit}, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tlast_o !== exp_pt.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $realtime,
                   exp_pt.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
    if (rst_ni) m_axis_tready_i <= ($urandom_range(0, 99) < 70) || (rand_gap() == 0);
  end

  task automatic add_hit(input hit_word_t hw);
    pending_hits = {pending_hits, hw};
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ORIGIN_X: origin_q[0] = value;
      REG_ORIGIN_Y: origin_q[1] = value;
      REG_ORIGIN_Z: origin_q[2] = value;
      REG_SAMPLE_STEP: step_q = value[30:0];
      REG_RANGE_LIMIT: range_q = value[30:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] stp,
                            input logic [31:0] rl);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SAMPLE_STEP, stp);
    write_reg(REG_RANGE_LIMIT, rl);
  endtask

  // Waits until every hit is in and every point is out, then lets a dropped
  // hit finish inside the block.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_hits.size() > 0 || s_axis_tvalid_i || expected_points.size() > 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] offset_coord(logic [31:0] org, longint span);
    longint v;
    v = longint'($signed(org)) + longint'($urandom_range(0, 32'(2 * span))) - span;
    return v[31:0];
  endfunction

  function automatic hit_word_t random_hit();
    int mode;
    longint span;
    logic [31:0] c[3];
    mode = $urandom_range(0, 99);
    span = longint'(step_q == 0 ? 1 : step_q) * $urandom_range(0, 90) / 2;
    if (span > 64'h3fff_ffff) span = 64'h3fff_ffff;
    for (int a = 0; a < 3; a++) begin
      if (mode < 65) c[a] = offset_coord(origin_q[a], span);
      else if (mode < 85) c[a] = $urandom;
      else if (mode < 93) c[a] = origin_q[a];
      else c[a] = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    end
    return {c[2], c[1], c[0]};
  endfunction

  initial begin
    logic [31:0] rl;
    origin_q = '{default: '0};
    step_q = 31'd6554;
    range_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: zero-length beam, short beams, long truncated beams.
    add_hit('0);
    add_hit({32'd0, 32'd0, 32'd6554});
    add_hit({32'd0, 32'd0, 32'd6555});
    add_hit({32'd0, 32'hffff_0000, 32'd40000});
    add_hit({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    add_hit({32'd0, 32'd0, 32'd406348});
    add_hit({32'd0, 32'd0, 32'd406349});
    drain();

    // Range limit including a hit exactly on the limit, unknown indexes.
    set_config(32'd100, 32'hffff_ff00, 32'd0, 32'h8000_0400, 32'd5000);
    write_reg(3'd5, 32'hffff_ffff);
    write_reg(3'd7, 32'h1234_5678);
    add_hit({32'd0, 32'hffff_ff00, 32'd5100});
    add_hit({32'd0, 32'hffff_ff00, 32'd5101});
    add_hit({32'd3000, 32'd3900, 32'd100});
    add_hit({32'd3000, 32'd2900, 32'd100});
    add_hit({32'd0, 32'hffff_ff00, 32'd100});
    drain();

    // Step written as zero behaves as a step of one.
    set_config(32'hffff_fff0, 32'd7, 32'd0, 32'd0, 32'd0);
    add_hit({32'd0, 32'd7, 32'hffff_fff0});
    add_hit({32'd0, 32'd7, 32'hffff_fff1});
    add_hit({32'd0, 32'd7, 32'hffff_fff2});
    add_hit({32'd3, 32'd11, 32'hffff_ffe0});
    add_hit({32'd0, 32'd7, 32'h0000_0030});
    drain();

    // Extreme origin, maximum step and range limit.
    set_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_hit({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    add_hit({32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
    add_hit({32'h0000_0000, 32'h0000_0000, 32'h8000_0000});
    add_hit({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    drain();

    // Random settings with random hits.
    for (int phase = 0; phase < 10; phase++) begin
      rl = '0;
      case ($urandom_range(0, 2))
        0: rl = '0;
        1: rl = $urandom_range(1, 40000);
        default: rl = $urandom;
      endcase
      set_config(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 200000) - 100000,
                 ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 200000) - 100000,
                 ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 200000) - 100000,
                 ($urandom_range(0, 3) != 0)
                   ? {1'($urandom_range(0, 1)), 31'($urandom_range(0, 3000))}
                   : $urandom,
                 rl);
      for (int j = 0; j < 13; j++) add_hit(random_hit());
      drain();
    end

    $display("Sent %0d hits (%0d dropped, %0d truncated), checked %0d points.",
             hits_sent, hits_dropped, truncated_beams, points_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
